FILE: src/sbbd_pkg.sv
`default_nettype none

package sbbd_pkg;

  // Block geometry
  localparam int BLOCK_W = 12;
  localparam logic [BLOCK_W-1:0] MIN_BLOCK = 12'd3;

  // Result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_BLOCK_SIZE = 1'b1;

  // Per-block inversion rule
  typedef enum logic [1:0] {
    RULE_ALL = 2'd0,
    RULE_ODD = 2'd1,
    RULE_THIRD = 2'd2
  } rule_t;

  // Configuration registers
  typedef struct packed {
    logic mode;
    logic [BLOCK_W-1:0] block_size;
  } cfg_t;

  // One queued transaction: one result, or two when a rotated block closes
  typedef struct packed {
    logic two;
    logic first_bit;
    logic held;
    logic done;
  } entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

`default_nettype wire

FILE: src/sbbd_front.sv
`default_nettype none

module sbbd_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sbbd_pkg::cfg_t cfg,
  input  wire logic accept,
  input  wire logic coded_bit,
  input  wire logic stream_end,
  output logic push,
  output sbbd_pkg::entry_t entry
);

  logic [sbbd_pkg::BLOCK_W-1:0] block_position;
  logic [1:0] third_phase;
  logic signed [12:0] balance_count;
  sbbd_pkg::rule_t current_rule;
  logic held_bit;

  logic [sbbd_pkg::BLOCK_W-1:0] size_eff;
  logic [sbbd_pkg::BLOCK_W:0] pos_inc;
  logic at_end;
  logic inv;
  logic plain;
  logic signed [12:0] balance_new;
  logic has_result;

  // Clamp the block size and detect the block end
  always_comb begin
    size_eff = (cfg.block_size < sbbd_pkg::MIN_BLOCK) ? sbbd_pkg::MIN_BLOCK : cfg.block_size;
    pos_inc = {1'b0, block_position} + {{sbbd_pkg::BLOCK_W{1'b0}}, 1'b1};
    at_end = stream_end || (pos_inc >= {1'b0, size_eff});
  end

  // Pick the inversion for this position
  always_comb begin
    unique case (current_rule)
      sbbd_pkg::RULE_ODD:   inv = block_position[0];
      sbbd_pkg::RULE_THIRD: inv = (third_phase == 2'd2);
      default:              inv = 1'b1;
    endcase
    plain = coded_bit ^ inv;
    balance_new = plain ? balance_count - 13'sd1 : balance_count + 13'sd1;
  end

  // Classify the transaction into a queue entry
  always_comb begin
    entry = '0;
    has_result = 1'b1;
    if (!cfg.mode) begin
      entry.first_bit = plain;
      entry.done = stream_end;
    end else if (block_position == '0) begin
      entry.first_bit = coded_bit;
      entry.done = stream_end;
      has_result = at_end;
    end else if (at_end) begin
      entry.two = 1'b1;
      entry.first_bit = coded_bit;
      entry.held = held_bit;
      entry.done = stream_end;
    end else begin
      entry.first_bit = coded_bit;
    end
    push = accept && has_result;
  end

  // Advance block state on each accepted bit
  always_ff @(posedge clk) begin
    if (rst) begin
      block_position <= '0;
      third_phase <= '0;
      balance_count <= '0;
      current_rule <= sbbd_pkg::RULE_ALL;
      held_bit <= 1'b0;
    end else if (accept) begin
      if (cfg.mode && block_position == '0 && !at_end) begin
        held_bit <= coded_bit;
      end
      if (at_end) begin
        block_position <= '0;
        third_phase <= '0;
        balance_count <= '0;
        if (stream_end) begin
          current_rule <= sbbd_pkg::RULE_ALL;
          held_bit <= 1'b0;
        end else if (!cfg.mode) begin
          if (balance_new == 13'sd0) begin
            current_rule <= sbbd_pkg::RULE_ALL;
          end else if (balance_new > 13'sd0) begin
            current_rule <= sbbd_pkg::RULE_ODD;
          end else begin
            current_rule <= sbbd_pkg::RULE_THIRD;
          end
        end
      end else begin
        block_position <= pos_inc[sbbd_pkg::BLOCK_W-1:0];
        third_phase <= (third_phase >= 2'd2) ? 2'd0 : third_phase + 2'd1;
        if (!cfg.mode) begin
          balance_count <= balance_new;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/sbbd_queue.sv
`default_nettype none

module sbbd_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire sbbd_pkg::entry_t push_entry,
  input  wire logic pop,
  output sbbd_pkg::entry_t head,
  output sbbd_pkg::qstat_t stat
);

  sbbd_pkg::entry_t slots [sbbd_pkg::QUEUE_DEPTH];
  logic [sbbd_pkg::QPTR_W-1:0] wr_ptr;
  logic [sbbd_pkg::QPTR_W-1:0] rd_ptr;
  logic [sbbd_pkg::QCNT_W-1:0] count;

  // Report fill state and present the oldest entry
  always_comb begin
    stat.empty = (count == '0);
    stat.full = (count == sbbd_pkg::QCNT_W'(sbbd_pkg::QUEUE_DEPTH));
    head = slots[rd_ptr];
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sbbd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sbbd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + sbbd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - sbbd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/sbbd_back.sv
`default_nettype none

module sbbd_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sbbd_pkg::entry_t head,
  input  wire sbbd_pkg::qstat_t stat,
  output logic pop,
  output logic out_valid,
  input  wire logic out_ready,
  output logic plain_bit,
  output logic run_last,
  output logic stream_done
);

  logic second;
  logic fire;

  // Drive the current result of the head entry
  always_comb begin
    out_valid = !stat.empty;
    fire = out_valid && out_ready;
    if (head.two && !second) begin
      plain_bit = head.first_bit;
      run_last = 1'b0;
      stream_done = 1'b0;
    end else begin
      plain_bit = head.two ? head.held : head.first_bit;
      run_last = 1'b1;
      stream_done = head.done;
    end
    pop = fire && (!head.two || second);
  end

  // Step through the results of a two-result entry
  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (fire) begin
      second <= head.two && !second;
    end
  end

endmodule

`default_nettype wire

FILE: src/seeded_block_bit_decoder.sv
`default_nettype none

// Seeded block bit decoder.
// Input channel (in_valid/in_ready) takes one coded bit per transaction with
// stream_end marking the final bit of a stream. Output channel
// (out_valid/out_ready) returns decoded bits with run_last and stream_done.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes mode
// (index 0) and block_size (index 1); write only while the block is idle.
// A result is registered in the result queue before it reaches the output.
// Throughput: one input bit per cycle while the queue is not full; a rotated
// block end yields two results, sent in turn, absorbed by a four-entry result
// queue between the classifying front end and the output sequencer.
// In mode 1 a block's first bit yields no result unless it ends the stream.
// Reset: configuration returns to mode 0, block size 4; block state, rule
// and queue clear. When the receiver stalls, results hold in the queue and
// in_ready drops once the queue fills; no result is lost.
module seeded_block_bit_decoder (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic cfg_index,
  input  wire logic [11:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic coded_bit,
  input  wire logic stream_end,
  output logic out_valid,
  input  wire logic out_ready,
  output logic plain_bit,
  output logic run_last,
  output logic stream_done
);

  sbbd_pkg::cfg_t cfg;
  sbbd_pkg::entry_t push_entry;
  sbbd_pkg::entry_t head;
  sbbd_pkg::qstat_t stat;
  logic push;
  logic pop;
  logic accept;

  assign cfg_ready = 1'b1;
  assign in_ready = !stat.full;
  assign accept = in_valid && in_ready;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= 1'b0;
      cfg.block_size <= 12'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sbbd_pkg::CFG_MODE:       cfg.mode <= cfg_data[0];
        sbbd_pkg::CFG_BLOCK_SIZE: cfg.block_size <= cfg_data;
      endcase
    end
  end

  sbbd_front u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .accept(accept),
    .coded_bit(coded_bit),
    .stream_end(stream_end),
    .push(push),
    .entry(push_entry)
  );

  sbbd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .pop(pop),
    .head(head),
    .stat(stat)
  );

  sbbd_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .stat(stat),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .plain_bit(plain_bit),
    .run_last(run_last),
    .stream_done(stream_done)
  );

endmodule

`default_nettype wire
